// File: rtl/i2c_bit_level_master_core_assert.svh
// Assertion macros shared by the I2C bit-level master checker
`ifndef I2C_BIT_LEVEL_MASTER_CORE_ASSERT_SVH
`define I2C_BIT_LEVEL_MASTER_CORE_ASSERT_SVH

// Clocked assertion, switched off while reset is asserted
`define I2CBLM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked assertion that is also checked through reset
`define I2CBLM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// File: rtl/i2cblm_pkg.sv
// Package: types, codes and tick constants of the I2C bit-level master
`timescale 1ns / 1ps
`default_nettype none
package i2cblm_pkg;

    // Input mode codes
    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_STOP  = 3'd2;
    localparam logic [2:0] MODE_WRITE = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;

    // Tick numbers within a command
    localparam logic [4:0] BIT_TICKS     = 5'd16;
    localparam logic [4:0] WR_ACK_TICK   = 5'd16;
    localparam logic [4:0] WR_POLL_TICK  = 5'd17;
    localparam logic [4:0] WR_LAST_TICK  = 5'd18;
    localparam logic [4:0] RD_ACK_HIGH   = 5'd18;
    localparam logic [4:0] RD_LAST_TICK  = 5'd20;

    localparam logic [7:0] POLL_LIMIT_RST = 8'hFF;

    // Running command
    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_READ
    } cmd_e;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       ack_to_send;
        logic       sda_level;
    } in_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_drive_enable;
        logic       sda_value;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic [7:0] ack_polls_left;
    } out_t;

    typedef struct packed {
        logic scl;
        logic drv;
        logic val;
    } pins_t;

    // Controller state handed between the top level and the tick logic
    typedef struct packed {
        cmd_e       cmd;
        logic [4:0] tick;
        logic [7:0] shift;
        logic [7:0] polls;
        logic       ack_choice;
        pins_t      pins;
    } st_t;

    // Released SDA always reads back as one
    function automatic pins_t drive_pins(input logic scl, input logic drv, input logic val);
        pins_t p;
        p.scl = scl;
        p.drv = drv;
        p.val = drv ? val : 1'b1;
        return p;
    endfunction

endpackage
`default_nettype wire

// File: rtl/i2cblm_step.sv
// Tick logic: next controller state and the result of one bus tick
`timescale 1ns / 1ps
`default_nettype none
module i2cblm_step (
    input  i2cblm_pkg::st_t  st_cur,
    input  i2cblm_pkg::in_t  item,
    input  logic [7:0]       poll_limit,
    output i2cblm_pkg::st_t  st_nxt,
    output i2cblm_pkg::out_t res
);

    i2cblm_pkg::st_t w;
    i2cblm_pkg::st_t n;
    logic            launch;
    logic            done;
    logic [7:0]      rx;
    logic [7:0]      polls;

    always_comb begin
        w      = st_cur;
        launch = 1'b0;
        done   = 1'b0;
        rx     = '0;
        polls  = '0;

        // A new command is taken only when idle; this tick is its first
        if (w.cmd == i2cblm_pkg::CMD_IDLE) begin
            case (item.mode)
                i2cblm_pkg::MODE_START: begin
                    w.cmd  = i2cblm_pkg::CMD_START;
                    launch = 1'b1;
                end
                i2cblm_pkg::MODE_STOP: begin
                    w.cmd  = i2cblm_pkg::CMD_STOP;
                    launch = 1'b1;
                end
                i2cblm_pkg::MODE_WRITE: begin
                    w.cmd  = i2cblm_pkg::CMD_WRITE;
                    launch = 1'b1;
                end
                i2cblm_pkg::MODE_READ: begin
                    w.cmd  = i2cblm_pkg::CMD_READ;
                    launch = 1'b1;
                end
                default: begin
                end
            endcase
            if (launch) begin
                w.tick       = '0;
                w.shift      = (w.cmd == i2cblm_pkg::CMD_WRITE) ? item.tx_byte : '0;
                w.ack_choice = item.ack_to_send;
                w.polls      = '0;
            end
        end

        n      = w;
        n.tick = w.tick + 5'd1;

        // Per-command tick sequences
        case (w.cmd)
            i2cblm_pkg::CMD_START: begin
                if (w.tick == 5'd0) begin
                    n.pins = i2cblm_pkg::drive_pins(1'b1, 1'b1, 1'b1);
                end else if (w.tick == 5'd1) begin
                    n.pins = i2cblm_pkg::drive_pins(1'b1, 1'b1, 1'b0);
                end else begin
                    n.pins = i2cblm_pkg::drive_pins(1'b0, 1'b1, 1'b0);
                    done   = 1'b1;
                end
            end
            i2cblm_pkg::CMD_STOP: begin
                if (w.tick == 5'd0) begin
                    n.pins = i2cblm_pkg::drive_pins(1'b1, 1'b1, 1'b0);
                end else begin
                    n.pins = i2cblm_pkg::drive_pins(1'b1, 1'b1, 1'b1);
                    done   = 1'b1;
                end
            end
            i2cblm_pkg::CMD_WRITE: begin
                if (w.tick < i2cblm_pkg::BIT_TICKS) begin
                    // data bit MSB first, SCL low then high
                    n.pins = i2cblm_pkg::drive_pins(w.tick[0], 1'b1, w.shift[7]);
                    if (w.tick[0]) begin
                        n.shift = {w.shift[6:0], 1'b0};
                    end
                end else if (w.tick == i2cblm_pkg::WR_ACK_TICK) begin
                    n.pins  = i2cblm_pkg::drive_pins(1'b0, 1'b0, 1'b1);
                    n.polls = poll_limit;
                end else if (w.tick == i2cblm_pkg::WR_POLL_TICK) begin
                    // stay on the poll tick until ACK seen or count spent
                    n.pins = i2cblm_pkg::drive_pins(1'b1, 1'b0, 1'b1);
                    if (w.polls == 8'd0 || !item.sda_level) begin
                        n.tick = i2cblm_pkg::WR_LAST_TICK;
                    end else begin
                        n.polls = w.polls - 8'd1;
                        n.tick  = i2cblm_pkg::WR_POLL_TICK;
                    end
                end else begin
                    n.pins = i2cblm_pkg::drive_pins(1'b0, 1'b0, 1'b1);
                    polls  = w.polls;
                    done   = 1'b1;
                end
            end
            i2cblm_pkg::CMD_READ: begin
                if (w.tick == 5'd0) begin
                    n.pins = i2cblm_pkg::drive_pins(1'b0, 1'b0, 1'b1);
                end else if (w.tick <= i2cblm_pkg::BIT_TICKS) begin
                    // sample on the SCL-high ticks
                    n.pins = i2cblm_pkg::drive_pins(w.tick[0], 1'b0, 1'b1);
                    if (w.tick[0]) begin
                        n.shift = {w.shift[6:0], item.sda_level};
                    end
                end else if (w.tick < i2cblm_pkg::RD_LAST_TICK) begin
                    n.pins = i2cblm_pkg::drive_pins(w.tick == i2cblm_pkg::RD_ACK_HIGH,
                                                    !w.ack_choice, 1'b0);
                end else begin
                    n.pins = i2cblm_pkg::drive_pins(1'b0, 1'b1, 1'b0);
                    rx     = w.shift;
                    done   = 1'b1;
                end
            end
            default: begin
                n.tick = w.tick;
            end
        endcase

        if (done) begin
            n.cmd = i2cblm_pkg::CMD_IDLE;
        end

        st_nxt             = n;
        res.scl_level      = n.pins.scl;
        res.sda_drive_enable = n.pins.drv;
        res.sda_value      = n.pins.val;
        res.busy_res       = (w.cmd != i2cblm_pkg::CMD_IDLE);
        res.done_res       = done;
        res.rx_byte        = rx;
        res.ack_polls_left = polls;
    end

endmodule
`default_nettype wire

// File: rtl/i2c_bit_level_master_core.sv
// I2C bit-level master with one bus tick per transfer.
// Each input transfer is one bus tick and yields one result transfer. The block takes a
// tick every clock cycle while s_ready is high; its result is registered in the output or
// skid register. The rate is set by the controller state register, which is updated once
// per tick through a single pass of the tick logic. A two-entry output stage (output
// register plus skid register) lets input transfers continue while a result waits to be
// taken. ack_poll_limit is written through cfg_wr_en/cfg_wr_data and resets to 255.
`timescale 1ns / 1ps
`default_nettype none
module i2c_bit_level_master_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [7:0]       cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  i2cblm_pkg::in_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output i2cblm_pkg::out_t m_data
);

    i2cblm_pkg::st_t  st_reg;
    i2cblm_pkg::st_t  st_next;
    i2cblm_pkg::out_t res;
    logic [7:0]       limit_reg;

    i2cblm_pkg::out_t out_reg;
    i2cblm_pkg::out_t out_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    i2cblm_pkg::out_t skid_reg;
    i2cblm_pkg::out_t skid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;

    logic             accept;
    logic             taken;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign taken   = out_valid_reg && m_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    i2cblm_step u_step (
        .st_cur     (st_reg),
        .item       (s_data),
        .poll_limit (limit_reg),
        .st_nxt     (st_next),
        .res        (res)
    );

    // Poll limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= i2cblm_pkg::POLL_LIMIT_RST;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    // Controller state, advanced once per accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.cmd        <= i2cblm_pkg::CMD_IDLE;
            st_reg.tick       <= '0;
            st_reg.shift      <= '0;
            st_reg.polls      <= '0;
            st_reg.ack_choice <= 1'b0;
            st_reg.pins       <= i2cblm_pkg::drive_pins(1'b1, 1'b0, 1'b1);
        end else if (accept) begin
            st_reg <= st_next;
        end
    end

    // Output register and skid register
    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || taken) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = res;
                out_valid_next = accept;
            end
        end else if (accept) begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule
`default_nettype wire

// File: rtl/i2cblm_checker.sv
// Port-level checker for the I2C bit-level master, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_bit_level_master_core_assert.svh"
module i2cblm_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_valid,
    input logic             m_ready,
    input i2cblm_pkg::out_t m_data
);

    // Stalled result transfer holds
    `I2CBLM_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "result changed while stalled")

    // Done only on a busy tick
    `I2CBLM_ASSERT(a_done_busy, m_valid && m_data.done_res |-> m_data.busy_res, "done without busy")

    // Received byte and poll count only on a final tick
    `I2CBLM_ASSERT(a_data_done, m_valid && (m_data.rx_byte != 8'd0 || m_data.ack_polls_left != 8'd0) |-> m_data.done_res, "data outside final tick")

    // Released SDA reads as one
    `I2CBLM_ASSERT(a_released, m_valid && !m_data.sda_drive_enable |-> m_data.sda_value, "released SDA not high")

    // Reset empties the output
    `I2CBLM_ASSERT_RST(a_rst_empty, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind i2c_bit_level_master_core i2cblm_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
